@@ rtl/core/counting_semaphore_wait_queue_assert.svh @@
// Assertion macros for the counting semaphore wait queue
`ifndef COUNTING_SEMAPHORE_WAIT_QUEUE_ASSERT_SVH
`define COUNTING_SEMAPHORE_WAIT_QUEUE_ASSERT_SVH

`ifndef SYNTHESIS

`define CSQ_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");

`define CSQ_ASSERT_NEVER(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("forbidden condition seen");

`else

`define CSQ_ASSERT(lbl, clk, rst_n, prop)

`define CSQ_ASSERT_NEVER(lbl, clk, rst_n, cond)

`endif

`endif

@@ rtl/core/csq_pkg.sv @@
// Package: types, codes and constants of the counting semaphore wait queue
`timescale 1ns / 1ps
`default_nettype none

package csq_pkg;

    localparam int MAX_WAITERS_DEF = 16;
    localparam int ID_BITS_DEF     = 8;

    localparam int CMD_W    = 3;
    localparam int ID_W     = 8;
    localparam int STATUS_W = 3;
    localparam int VALUE_W  = 17;
    localparam int COUNT_W  = 18;
    localparam int CFG_W    = 16;
    localparam int APB_W    = 32;
    localparam int ADDR_W   = 3;

    localparam logic signed [COUNT_W-1:0] TOP_COUNT = 18'sd65535;

    localparam logic [CMD_W-1:0] CMD_WAIT     = 3'd0;
    localparam logic [CMD_W-1:0] CMD_POST     = 3'd1;
    localparam logic [CMD_W-1:0] CMD_TRY_TAKE = 3'd2;
    localparam logic [CMD_W-1:0] CMD_QUERY    = 3'd3;
    localparam logic [CMD_W-1:0] CMD_TAKE_ALL = 3'd4;
    localparam logic [CMD_W-1:0] CMD_POST_ALL = 3'd5;
    localparam logic [CMD_W-1:0] CMD_CANCEL   = 3'd6;

    localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
    localparam logic [STATUS_W-1:0] ST_QUEUED    = 3'd1;
    localparam logic [STATUS_W-1:0] ST_FULL      = 3'd2;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd3;
    localparam logic [STATUS_W-1:0] ST_NOT_AVAIL = 3'd4;

    localparam logic [ADDR_W-1:0] REG_INIT_COUNT = 3'd0;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CANCEL,
        S_DRAIN
    } t_state;

    typedef struct packed {
        logic load;
        logic shift;
    } t_cell_ctl;

endpackage

`default_nettype wire

@@ rtl/core/csq_cell.sv @@
// One slot of the waiter queue: loads a new id or takes its right neighbor's id
`timescale 1ns / 1ps
`default_nettype none

module csq_cell
    import csq_pkg::*;
#(
    parameter int ID_BITS = ID_BITS_DEF
) (
    input  wire logic               i_clk,
    input  wire t_cell_ctl          i_ctl,
    input  wire logic [ID_BITS-1:0] i_load_id,
    input  wire logic [ID_BITS-1:0] i_next_id,
    output logic      [ID_BITS-1:0] o_id
);

    logic [ID_BITS-1:0] r_id;

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_id <= i_load_id;
        end else if (i_ctl.shift) begin
            r_id <= i_next_id;
        end
    end

    assign o_id = r_id;

endmodule

`default_nettype wire

@@ rtl/core/counting_semaphore_wait_queue.sv @@
// Top level: counting semaphore with a FIFO wait queue built as a row of cells
//
//  channel   | ports                                   | handshake
//  ----------+-----------------------------------------+----------------------------
//  request   | i_cmd, i_requester_id                   | start high and busy low
//  result    | o_status, o_woken_valid, o_woken_id,    | o_valid, one cycle per
//            | o_value, o_last                         | result, no backpressure
//  config    | psel, penable, pwrite, paddr, pwdata,   | APB write, pready tied high
//            | prdata, pready                          |
//
//  Wait, post, try-take, query, take-all and unused codes: result one cycle after
//  the request; busy stays low, so a request may follow in every cycle.
//  Post-all: one result per waiter, one per cycle, as the cells shift to the head.
//  Cancel: the queue rotates once through the cells, then one result.
//  Reset loads count 0 and empties the queue; the queue cells need no clearing.
//  The receiver cannot stall: each result shows for exactly one cycle.
`timescale 1ns / 1ps
`default_nettype none

`include "counting_semaphore_wait_queue_assert.svh"

module counting_semaphore_wait_queue
    import csq_pkg::*;
#(
    parameter int MAX_WAITERS = MAX_WAITERS_DEF,
    parameter int ID_BITS     = ID_BITS_DEF
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       start,
    output logic                            busy,
    input  wire logic [CMD_W-1:0]           i_cmd,
    input  wire logic [ID_W-1:0]            i_requester_id,
    output logic                            o_valid,
    output logic      [STATUS_W-1:0]        o_status,
    output logic                            o_woken_valid,
    output logic      [ID_W-1:0]            o_woken_id,
    output logic signed [VALUE_W-1:0]       o_value,
    output logic                            o_last,
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [ADDR_W-1:0]          paddr,
    input  wire logic [APB_W-1:0]           pwdata,
    output logic      [APB_W-1:0]           prdata,
    output logic                            pready
);

    localparam int OCC_W = $clog2(MAX_WAITERS + 1);

    t_state                      r_state, n_state;
    logic signed [COUNT_W-1:0]   r_count, n_count;
    logic [OCC_W-1:0]            r_occ, n_occ;
    logic [OCC_W-1:0]            r_steps, n_steps;
    logic [OCC_W-1:0]            r_total, n_total;
    logic                        r_found, n_found;
    logic [ID_BITS-1:0]          r_cid, n_cid;
    logic [CFG_W-1:0]            r_init;

    logic                        r_valid, n_valid;
    logic [STATUS_W-1:0]         r_status, n_status;
    logic                        r_wv, n_wv;
    logic [ID_W-1:0]             r_wid, n_wid;
    logic signed [VALUE_W-1:0]   r_value, n_value;
    logic                        r_last, n_last;

    logic                        q_shift;
    logic                        q_wr;
    logic [OCC_W-1:0]            q_wr_idx;
    logic [ID_BITS-1:0]          q_wr_data;
    logic [ID_BITS-1:0]          cell_id [MAX_WAITERS];
    logic [ID_BITS-1:0]          head;
    logic [ID_BITS-1:0]          in_id;

    logic                        accept;
    logic                        cfg_we;
    logic                        cnt_pos;
    logic                        drop;

    assign accept  = start && !busy;
    assign busy    = (r_state != S_IDLE);
    assign cfg_we  = psel && penable && pwrite && (paddr == REG_INIT_COUNT)
                     && (r_state == S_IDLE) && !start;
    assign pready  = 1'b1;
    assign prdata  = (paddr == REG_INIT_COUNT) ? APB_W'(r_init) : '0;
    assign in_id   = ID_BITS'(i_requester_id);
    assign head    = cell_id[0];
    assign cnt_pos = !r_count[COUNT_W-1] && (r_count != '0);
    assign drop    = !r_found && (head == r_cid);

    for (genvar g = 0; g < MAX_WAITERS; g++) begin : g_cell
        t_cell_ctl          ctl;
        logic [ID_BITS-1:0] next_id;

        assign ctl.load  = q_wr && (q_wr_idx == OCC_W'(g));
        assign ctl.shift = q_shift;

        if (g == MAX_WAITERS - 1) begin : g_end
            assign next_id = cell_id[g];
        end else begin : g_mid
            assign next_id = cell_id[g + 1];
        end

        csq_cell #(
            .ID_BITS (ID_BITS)
        ) u_cell (
            .i_clk     (i_clk),
            .i_ctl     (ctl),
            .i_load_id (q_wr_data),
            .i_next_id (next_id),
            .o_id      (cell_id[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_occ   <= '0;
            r_init  <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
            if (cfg_we) begin
                r_init  <= pwdata[CFG_W-1:0];
                r_count <= COUNT_W'(pwdata[CFG_W-1:0]);
                r_occ   <= '0;
            end else begin
                r_count <= n_count;
                r_occ   <= n_occ;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_steps  <= n_steps;
        r_total  <= n_total;
        r_found  <= n_found;
        r_cid    <= n_cid;
        r_status <= n_status;
        r_wv     <= n_wv;
        r_wid    <= n_wid;
        r_value  <= n_value;
        r_last   <= n_last;
    end

    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_occ     = r_occ;
        n_steps   = r_steps;
        n_total   = r_total;
        n_found   = r_found;
        n_cid     = r_cid;
        n_valid   = 1'b0;
        n_status  = ST_OK;
        n_wv      = 1'b0;
        n_wid     = '0;
        n_value   = '0;
        n_last    = 1'b1;
        q_shift   = 1'b0;
        q_wr      = 1'b0;
        q_wr_idx  = r_occ;
        q_wr_data = in_id;

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_valid = 1'b1;
                    case (i_cmd)
                        CMD_WAIT: begin
                            if (cnt_pos) begin
                                n_count = r_count - 18'sd1;
                            end else if (r_occ >= OCC_W'(MAX_WAITERS)) begin
                                n_status = ST_FULL;
                            end else begin
                                q_wr     = 1'b1;
                                n_occ    = r_occ + OCC_W'(1);
                                n_count  = r_count - 18'sd1;
                                n_status = ST_QUEUED;
                            end
                        end
                        CMD_POST: begin
                            if (r_occ != '0) begin
                                q_shift = 1'b1;
                                n_occ   = r_occ - OCC_W'(1);
                                n_count = r_count + 18'sd1;
                                n_wv    = 1'b1;
                                n_wid   = ID_W'(head);
                            end else if (r_count < TOP_COUNT) begin
                                n_count = r_count + 18'sd1;
                            end
                        end
                        CMD_TRY_TAKE: begin
                            if (cnt_pos) begin
                                n_count = r_count - 18'sd1;
                            end else begin
                                n_status = ST_NOT_AVAIL;
                            end
                        end
                        CMD_QUERY: begin
                            n_value = r_count[VALUE_W-1:0];
                        end
                        CMD_TAKE_ALL: begin
                            if (cnt_pos) begin
                                n_value = r_count[VALUE_W-1:0];
                                n_count = '0;
                            end
                        end
                        CMD_POST_ALL: begin
                            if (r_occ != '0) begin
                                n_valid = 1'b0;
                                n_total = r_occ;
                                n_state = S_DRAIN;
                            end
                        end
                        CMD_CANCEL: begin
                            if (r_occ != '0) begin
                                n_valid = 1'b0;
                                n_steps = r_occ;
                                n_found = 1'b0;
                                n_cid   = in_id;
                                n_state = S_CANCEL;
                            end else begin
                                n_status = ST_NOT_FOUND;
                            end
                        end
                        default: begin
                            n_status = ST_NOT_AVAIL;
                        end
                    endcase
                end
            end
            S_DRAIN: begin
                n_valid = 1'b1;
                n_wv    = 1'b1;
                n_wid   = ID_W'(head);
                n_value = VALUE_W'(r_total);
                n_last  = (r_occ == OCC_W'(1));
                q_shift = 1'b1;
                n_occ   = r_occ - OCC_W'(1);
                if (r_occ == OCC_W'(1)) begin
                    n_count = '0;
                    n_state = S_IDLE;
                end
            end
            S_CANCEL: begin
                q_shift   = 1'b1;
                q_wr_data = head;
                q_wr_idx  = r_occ - OCC_W'(1);
                n_steps   = r_steps - OCC_W'(1);
                if (drop) begin
                    n_occ   = r_occ - OCC_W'(1);
                    n_found = 1'b1;
                end else begin
                    q_wr = 1'b1;
                end
                if (r_steps == OCC_W'(1)) begin
                    n_valid = 1'b1;
                    n_state = S_IDLE;
                    if (r_found || drop) begin
                        n_count = r_count + 18'sd1;
                    end else begin
                        n_status = ST_NOT_FOUND;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_valid       = r_valid;
    assign o_status      = r_status;
    assign o_woken_valid = r_wv;
    assign o_woken_id    = r_wid;
    assign o_value       = r_value;
    assign o_last        = r_last;

    `CSQ_ASSERT_NEVER(a_occ_bound, i_clk, i_rst_n, r_occ > OCC_W'(MAX_WAITERS))

    `CSQ_ASSERT(a_count_matches_queue, i_clk, i_rst_n, (r_state == S_IDLE) |-> (r_count[COUNT_W-1] ? ((r_count + COUNT_W'(r_occ)) == '0) : (r_occ == '0)))

    `CSQ_ASSERT(a_request_answered, i_clk, i_rst_n, accept |=> (o_valid || busy))

endmodule

`default_nettype wire
